FILE: sv/nstf_pkg.sv
package nstf_pkg;

    localparam int unsigned FRAC_BITS_DEF   = 32;
    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned LEN_WIDTH       = 16;
    localparam int unsigned VALUE_WIDTH     = 64;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // floor(x / 10) for any 32-bit x: (x * RECIP10) >> RECIP10_SHIFT
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned RECIP10_SHIFT = 35;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    function automatic t_digit nstf_digit(input logic [7:0] c, input logic hex);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_ZERO);
        end else if (hex && c >= CH_UA && c <= CH_UF) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_UA) + 4'd10;
        end else if (hex && c >= CH_LA && c <= CH_LF) begin
            d.ok  = 1'b1;
            d.val = 4'(c - CH_LA) + 4'd10;
        end
        return d;
    endfunction

    function automatic logic nstf_is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: sv/numeric_string_to_fixed_unit.sv
// Streaming number parser: one ASCII character per word, base 10 or 16 set by the
// configuration register, value returned as signed fixed point with FRAC_BITS fraction
// bits. The block takes one character every cycle; a result word appears in the output
// register the cycle after the character that ends the number (or the stray character
// met between numbers) is accepted, and the next character is taken in that same cycle
// unless the output register is full and not being drained. The longest path per
// character is the base-10 place-scale update, a 32 x 32 multiply by a reciprocal.
module numeric_string_to_fixed_unit
    import nstf_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_hex_base,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_character,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [VALUE_WIDTH-1:0] o_value,
    output logic [LEN_WIDTH-1:0]   o_consumed_length,
    output logic                   o_saturated
);

    localparam int unsigned IW     = VALUE_WIDTH - 1 - FRAC_BITS;
    localparam int unsigned LW     = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
    localparam logic [FRAC_BITS-1:0] SCALE10 = FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd10);
    localparam logic [FRAC_BITS-1:0] SCALE16 = FRAC_BITS'(64'd1 << (FRAC_BITS - 4));
    localparam logic [VALUE_WIDTH-1:0] MAG_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic                     r_hex;
    t_phase                   r_phase,   n_phase;
    logic                     r_neg,     n_neg;
    logic [VALUE_WIDTH-1:0]   r_acc,     n_acc;
    logic [FRAC_BITS-1:0]     r_scale,   n_scale;
    logic [COUNT_WIDTH-1:0]   r_count,   n_count;
    logic                     r_ovf,     n_ovf;

    logic                     r_out_valid;
    logic [VALUE_WIDTH-1:0]   r_value,   n_value;
    logic [LEN_WIDTH-1:0]     r_len,     n_len;
    logic                     r_sat,     n_sat;

    logic                     accept;
    logic                     emit;
    logic                     in_idle;
    t_digit                   dig;
    logic [IW-1:0]            ip;
    logic [IW+4:0]            nip;
    logic [63:0]              div_prod;
    logic [FRAC_BITS+3:0]     frac_add;
    logic [FRAC_BITS-1:0]     scale_init;
    logic [LW-1:0]            count_ext;
    logic [VALUE_WIDTH-1:0]   mag;

    t_phase                   b_phase;
    logic                     b_neg;
    logic [VALUE_WIDTH-1:0]   b_acc;
    logic [FRAC_BITS-1:0]     b_scale;
    logic [COUNT_WIDTH-1:0]   b_count;
    logic                     b_ovf;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign accept      = i_valid && o_ready;

    assign o_valid           = r_out_valid;
    assign o_value           = r_value;
    assign o_consumed_length = r_len;
    assign o_saturated       = r_sat;

    assign dig        = nstf_digit(i_character, r_hex);
    assign in_idle    = !(r_phase == PH_INT || r_phase == PH_FRAC);
    assign scale_init = r_hex ? SCALE16 : SCALE10;

    // integer step: ip * base + digit, base 10 as shift-add
    assign ip  = r_acc[FRAC_BITS +: IW];
    assign nip = r_hex ? (((IW+5)'(ip)) << 4) + (IW+5)'(dig.val)
                       : (((IW+5)'(ip)) << 3) + (((IW+5)'(ip)) << 1) + (IW+5)'(dig.val);

    // fraction step
    assign frac_add = (FRAC_BITS+4)'(dig.val) * (FRAC_BITS+4)'(r_scale);
    assign div_prod = 64'(32'(r_scale)) * 64'(RECIP10);

    assign count_ext = LW'(r_count);
    assign mag       = r_acc & MAG_MAX;

    function automatic logic [COUNT_WIDTH-1:0] count_one(input logic [COUNT_WIDTH-1:0] c);
        return (c == {COUNT_WIDTH{1'b1}}) ? c : c + COUNT_WIDTH'(1);
    endfunction

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_scale = r_scale;
        n_count = r_count;
        n_ovf   = r_ovf;
        emit    = 1'b0;
        n_value = r_value;
        n_sat   = r_sat;
        n_len   = (count_ext > LW'({LEN_WIDTH{1'b1}})) ? {LEN_WIDTH{1'b1}}
                                                       : count_ext[LEN_WIDTH-1:0];
        b_phase = r_phase;
        b_neg   = r_neg;
        b_acc   = r_acc;
        b_scale = r_scale;
        b_count = r_count;
        b_ovf   = r_ovf;

        if (!in_idle && dig.ok) begin
            n_count = count_one(r_count);
            if (!r_ovf) begin
                if (r_phase == PH_INT) begin
                    if (nip[IW+4:IW] != '0) begin
                        n_ovf = 1'b1;
                        n_acc = MAG_MAX;
                    end else begin
                        n_acc = {1'b0, nip[IW-1:0], {FRAC_BITS{1'b0}}};
                    end
                end else begin
                    n_acc   = r_acc + VALUE_WIDTH'(frac_add);
                    n_scale = r_hex ? (r_scale >> 4)
                                    : FRAC_BITS'(div_prod >> RECIP10_SHIFT);
                end
            end
        end else if (r_phase == PH_INT && i_character == CH_DOT) begin
            n_count = count_one(r_count);
            n_phase = PH_FRAC;
            n_scale = scale_init;
        end else begin
            // in a number this ends it: emit it, then restart from a cleared state
            if (!in_idle) begin
                emit    = 1'b1;
                n_value = r_neg ? (~mag + VALUE_WIDTH'(1)) : mag;
                n_sat   = r_ovf;
                b_phase = PH_IDLE;
                b_neg   = 1'b0;
                b_acc   = '0;
                b_scale = '0;
                b_count = '0;
                b_ovf   = 1'b0;
            end
            n_phase = b_phase;
            n_neg   = b_neg;
            n_acc   = b_acc;
            n_scale = b_scale;
            n_count = b_count;
            n_ovf   = b_ovf;
            if (nstf_is_space(i_character)) begin
                n_count = count_one(b_count);
            end else if (i_character == CH_MINUS || i_character == CH_PLUS) begin
                n_neg   = (i_character == CH_MINUS);
                n_phase = PH_INT;
                n_count = count_one(b_count);
            end else if (dig.ok) begin
                n_acc   = VALUE_WIDTH'(dig.val) << FRAC_BITS;
                n_phase = PH_INT;
                n_count = count_one(b_count);
            end else if (i_character == CH_DOT) begin
                n_phase = PH_FRAC;
                n_scale = scale_init;
                n_count = count_one(b_count);
            end else begin
                // stray character: report zero between numbers, drop it either way
                if (in_idle) begin
                    emit    = 1'b1;
                    n_value = '0;
                    n_sat   = 1'b0;
                end
                n_phase = PH_IDLE;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_scale = '0;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex       <= 1'b0;
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_scale     <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_hex <= i_cfg_hex_base;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_scale <= n_scale;
                r_count <= n_count;
                r_ovf   <= n_ovf;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word, loaded only when a new word is emitted
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_value <= n_value;
            r_len   <= n_len;
            r_sat   <= n_sat;
        end
    end

endmodule
